@@ rtl/qvr_pkg.sv @@
`timescale 1ns / 1ps
package qvr_pkg;

	localparam int VEC_W   = 32;
	localparam int QFRAC   = 16;
	localparam int QUAT_W  = QFRAC + 2;
	localparam int P1_W    = VEC_W + QUAT_W;
	localparam int S1_W    = P1_W + 2;
	localparam int T_W     = S1_W - QFRAC;
	localparam int P2_W    = T_W + QUAT_W;
	localparam int S2_W    = P2_W + 2;
	localparam int R_W     = S2_W - QFRAC;
	localparam int IN_W    = 3 * VEC_W + 4 * QUAT_W;
	localparam int OUT_W   = 3 * VEC_W;

	typedef logic signed [VEC_W-1:0]  vec_t;
	typedef logic signed [QUAT_W-1:0] qcomp_t;
	typedef logic signed [T_W-1:0]    tcomp_t;

	typedef struct packed {
		qcomp_t w;
		qcomp_t k;
		qcomp_t j;
		qcomp_t i;
	} quat_t;

	typedef struct packed {
		tcomp_t w;
		tcomp_t z;
		tcomp_t y;
		tcomp_t x;
	} tquat_t;

	typedef struct packed {
		logic en_s4;
		logic en_s3;
		logic en_s2;
		logic en_s1;
	} pipe_ctl_t;

endpackage

@@ rtl/qvr_lmul.sv @@
`timescale 1ns / 1ps
module qvr_lmul (
	input  logic                 clk,
	input  qvr_pkg::pipe_ctl_t   ctl,
	input  qvr_pkg::vec_t        vector_x,
	input  qvr_pkg::vec_t        vector_y,
	input  qvr_pkg::vec_t        vector_z,
	input  qvr_pkg::quat_t       rot,
	output qvr_pkg::tquat_t      t_s2,
	output qvr_pkg::quat_t       q_s2
);

	localparam int P_W = qvr_pkg::P1_W;
	localparam int S_W = qvr_pkg::S1_W;
	localparam int F   = qvr_pkg::QFRAC;
	localparam logic signed [S_W-1:0] HALF = S_W'(1) <<< (F - 1);

	logic signed [P_W-1:0] p_s1 [12];
	qvr_pkg::quat_t        q_s1;

	logic signed [S_W-1:0] sum_x, sum_y, sum_z, sum_w;
	logic signed [S_W-1:0] rnd_x, rnd_y, rnd_z, rnd_w;

	// stage 1: twelve products of the vector with the quaternion
	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			p_s1[0]  <= rot.w * vector_x;
			p_s1[1]  <= rot.j * vector_z;
			p_s1[2]  <= rot.k * vector_y;
			p_s1[3]  <= rot.w * vector_y;
			p_s1[4]  <= rot.i * vector_z;
			p_s1[5]  <= rot.k * vector_x;
			p_s1[6]  <= rot.w * vector_z;
			p_s1[7]  <= rot.i * vector_y;
			p_s1[8]  <= rot.j * vector_x;
			p_s1[9]  <= rot.i * vector_x;
			p_s1[10] <= rot.j * vector_y;
			p_s1[11] <= rot.k * vector_z;
			q_s1     <= rot;
		end
	end

	// stage 2: t = q * (v, 0), rounded half up
	always_comb begin
		sum_x = S_W'(p_s1[0]) + S_W'(p_s1[1]) - S_W'(p_s1[2]);
		sum_y = S_W'(p_s1[3]) - S_W'(p_s1[4]) + S_W'(p_s1[5]);
		sum_z = S_W'(p_s1[6]) + S_W'(p_s1[7]) - S_W'(p_s1[8]);
		sum_w = -S_W'(p_s1[9]) - S_W'(p_s1[10]) - S_W'(p_s1[11]);
		rnd_x = sum_x + HALF;
		rnd_y = sum_y + HALF;
		rnd_z = sum_z + HALF;
		rnd_w = sum_w + HALF;
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			t_s2.x <= $signed(rnd_x[S_W-1:F]);
			t_s2.y <= $signed(rnd_y[S_W-1:F]);
			t_s2.z <= $signed(rnd_z[S_W-1:F]);
			t_s2.w <= $signed(rnd_w[S_W-1:F]);
			q_s2   <= q_s1;
		end
	end

endmodule

@@ rtl/qvr_rmul.sv @@
`timescale 1ns / 1ps
module qvr_rmul (
	input  logic                 clk,
	input  qvr_pkg::pipe_ctl_t   ctl,
	input  qvr_pkg::tquat_t      t_s2,
	input  qvr_pkg::quat_t       q_s2,
	output qvr_pkg::vec_t        rot_x_s4,
	output qvr_pkg::vec_t        rot_y_s4,
	output qvr_pkg::vec_t        rot_z_s4,
	output logic                 sat_s4
);

	localparam int P_W = qvr_pkg::P2_W;
	localparam int S_W = qvr_pkg::S2_W;
	localparam int R_W = qvr_pkg::R_W;
	localparam int V_W = qvr_pkg::VEC_W;
	localparam int F   = qvr_pkg::QFRAC;
	localparam logic signed [S_W-1:0] HALF = S_W'(1) <<< (F - 1);

	logic signed [P_W-1:0] p_s3 [12];

	logic signed [S_W-1:0] sum_x, sum_y, sum_z;
	logic signed [S_W-1:0] rnd_x, rnd_y, rnd_z;
	qvr_pkg::vec_t         clp_x, clp_y, clp_z;
	logic                  ov_x, ov_y, ov_z;

	function automatic qvr_pkg::vec_t clip(input logic signed [R_W-1:0] r,
			output logic ov);
		logic hi_pos, hi_neg;
		hi_pos = ~r[R_W-1] & (|r[R_W-2:V_W-1]);
		hi_neg = r[R_W-1] & ~(&r[R_W-2:V_W-1]);
		ov = hi_pos | hi_neg;
		if (hi_pos)
			clip = {1'b0, {(V_W-1){1'b1}}};
		else if (hi_neg)
			clip = {1'b1, {(V_W-1){1'b0}}};
		else
			clip = r[V_W-1:0];
	endfunction

	// stage 3: products of t with conj(q)
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			p_s3[0]  <= t_s2.w * q_s2.i;
			p_s3[1]  <= t_s2.x * q_s2.w;
			p_s3[2]  <= t_s2.y * q_s2.k;
			p_s3[3]  <= t_s2.z * q_s2.j;
			p_s3[4]  <= t_s2.w * q_s2.j;
			p_s3[5]  <= t_s2.x * q_s2.k;
			p_s3[6]  <= t_s2.y * q_s2.w;
			p_s3[7]  <= t_s2.z * q_s2.i;
			p_s3[8]  <= t_s2.w * q_s2.k;
			p_s3[9]  <= t_s2.x * q_s2.j;
			p_s3[10] <= t_s2.y * q_s2.i;
			p_s3[11] <= t_s2.z * q_s2.w;
		end
	end

	// stage 4: sum, round half up, clip to the vector range
	always_comb begin
		sum_x = -S_W'(p_s3[0]) + S_W'(p_s3[1]) - S_W'(p_s3[2]) + S_W'(p_s3[3]);
		sum_y = -S_W'(p_s3[4]) + S_W'(p_s3[5]) + S_W'(p_s3[6]) - S_W'(p_s3[7]);
		sum_z = -S_W'(p_s3[8]) - S_W'(p_s3[9]) + S_W'(p_s3[10]) + S_W'(p_s3[11]);
		rnd_x = sum_x + HALF;
		rnd_y = sum_y + HALF;
		rnd_z = sum_z + HALF;
		clp_x = clip($signed(rnd_x[S_W-1:F]), ov_x);
		clp_y = clip($signed(rnd_y[S_W-1:F]), ov_y);
		clp_z = clip($signed(rnd_z[S_W-1:F]), ov_z);
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			rot_x_s4 <= clp_x;
			rot_y_s4 <= clp_y;
			rot_z_s4 <= clp_z;
			sat_s4   <= ov_x | ov_y | ov_z;
		end
	end

endmodule

@@ rtl/quaternion_vector_rotate_core.sv @@
`timescale 1ns / 1ps
// throughput: one beat per cycle while the output is not stalled; four register stages, two per hamilton product
// a stalled output fills the empty stages before input backpressure appears
// reset: arst_n clears the stage valid bits only, the data registers are not reset
module quaternion_vector_rotate_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// vector_x, vector_y, vector_z, rot_i, rot_j, rot_k, rot_real
	input  logic [qvr_pkg::IN_W-1:0]      s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// rotated_x, rotated_y, rotated_z
	output logic [qvr_pkg::OUT_W-1:0]     m_axis_tdata,
	// saturated
	output logic                          m_axis_tuser
);

	localparam int V_W = qvr_pkg::VEC_W;
	localparam int Q_W = qvr_pkg::QUAT_W;
	localparam int QB  = 3 * V_W;

	qvr_pkg::pipe_ctl_t ctl;
	logic               valid_s1, valid_s2, valid_s3, valid_s4;

	qvr_pkg::vec_t      in_x, in_y, in_z;
	qvr_pkg::quat_t     in_q;
	qvr_pkg::tquat_t    t_s2;
	qvr_pkg::quat_t     q_s2;
	qvr_pkg::vec_t      rot_x_s4, rot_y_s4, rot_z_s4;
	logic               sat_s4;

	assign in_x   = $signed(s_axis_tdata[V_W-1:0]);
	assign in_y   = $signed(s_axis_tdata[2*V_W-1:V_W]);
	assign in_z   = $signed(s_axis_tdata[3*V_W-1:2*V_W]);
	assign in_q.i = $signed(s_axis_tdata[QB+Q_W-1:QB]);
	assign in_q.j = $signed(s_axis_tdata[QB+2*Q_W-1:QB+Q_W]);
	assign in_q.k = $signed(s_axis_tdata[QB+3*Q_W-1:QB+2*Q_W]);
	assign in_q.w = $signed(s_axis_tdata[QB+4*Q_W-1:QB+3*Q_W]);

	// a stage moves when it is empty or the stage after it moves
	always_comb begin
		ctl.en_s4 = ~valid_s4 | m_axis_tready;
		ctl.en_s3 = ~valid_s3 | ctl.en_s4;
		ctl.en_s2 = ~valid_s2 | ctl.en_s3;
		ctl.en_s1 = ~valid_s1 | ctl.en_s2;
	end

	assign s_axis_tready = ctl.en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ctl.en_s1)
				valid_s1 <= s_axis_tvalid;
			if (ctl.en_s2)
				valid_s2 <= valid_s1;
			if (ctl.en_s3)
				valid_s3 <= valid_s2;
			if (ctl.en_s4)
				valid_s4 <= valid_s3;
		end
	end

	qvr_lmul u_lmul (
		.clk      (clk),
		.ctl      (ctl),
		.vector_x (in_x),
		.vector_y (in_y),
		.vector_z (in_z),
		.rot      (in_q),
		.t_s2     (t_s2),
		.q_s2     (q_s2)
	);

	qvr_rmul u_rmul (
		.clk      (clk),
		.ctl      (ctl),
		.t_s2     (t_s2),
		.q_s2     (q_s2),
		.rot_x_s4 (rot_x_s4),
		.rot_y_s4 (rot_y_s4),
		.rot_z_s4 (rot_z_s4),
		.sat_s4   (sat_s4)
	);

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = {rot_z_s4, rot_y_s4, rot_x_s4};
	assign m_axis_tuser  = sat_s4;

	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.en_s2 && valid_s1) |=> valid_s2)
		else $error("beat lost between stage 1 and stage 2");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !ctl.en_s2) |=> valid_s2)
		else $error("stalled stage 2 beat dropped");

	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s4 || !valid_s3 || !valid_s2 || !valid_s1) |-> s_axis_tready)
		else $error("input stalled while the pipeline has a bubble");

	a_s3_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.en_s3 |-> (valid_s3 && valid_s4 && !m_axis_tready))
		else $error("stage 3 stalled without a blocked output");

endmodule
